// ----- rtl/waypoint_curvature_steer_feedforward_defines.svh -----
// Assertion macros for the waypoint steering feedforward block.
// Included by the top level; no other dependencies.
`ifndef WAYPOINT_CURVATURE_STEER_FEEDFORWARD_DEFINES_SVH
`define WAYPOINT_CURVATURE_STEER_FEEDFORWARD_DEFINES_SVH
`ifndef SYNTHESIS
`define WCSF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("wcsf check failed");
`define WCSF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("wcsf check failed");
`else
`define WCSF_ASSERT_IMP(lbl, ante, cons)
`define WCSF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/wcsf_pkg.sv -----
// Shared types, widths and tables for the waypoint steering feedforward block.
// No dependencies.
package wcsf_pkg;
	localparam int ATAN_STEPS = 16;
	localparam int STEP_W = $clog2(ATAN_STEPS);
	localparam int MUL_A_W = 70;
	localparam int MUL_B_W = 35;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int SQ_IN_W = 66;
	localparam int SQ_OUT_W = 33;
	localparam int ACC_W = 68;
	localparam int CORD_W = 34;
	localparam int ANGLE_MAX = 12868;
	localparam int ANG_W = 14;

	typedef enum logic [4:0] {
		S_IDLE, S_DET0, S_DET1, S_CRS0, S_CRS1,
		S_LA0, S_LA1, S_LA2, S_LB0, S_LB1, S_LB2, S_LC0, S_LC1, S_LC2,
		S_PAB, S_PABC, S_NUM, S_ANG, S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_PAST = 2'd1, ST_SHORT = 2'd2
	} status_t;

	function automatic logic signed [32:0] sdiff(logic signed [31:0] a, logic signed [31:0] b);
		return {a[31], a} - {b[31], b};
	endfunction

	function automatic logic [32:0] mag33(logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	// atan(2^-i) in Q2.30, truncated
	function automatic logic [30:0] atan_q30(logic [4:0] i);
		logic [30:0] r;
		case (i)
			5'd0: r = 31'h3243F6A8;
			5'd1: r = 31'h1DAC6705;
			5'd2: r = 31'h0FADBAFC;
			5'd3: r = 31'h07F56EA6;
			5'd4: r = 31'h03FEAB76;
			5'd5: r = 31'h01FFD55B;
			5'd6: r = 31'h00FFFAAA;
			5'd7: r = 31'h007FFF55;
			5'd8: r = 31'h003FFFEA;
			5'd9: r = 31'h001FFFFD;
			5'd10: r = 31'h000FFFFF;
			5'd11: r = 31'h0007FFFF;
			5'd12: r = 31'h0003FFFF;
			5'd13: r = 31'h0001FFFF;
			5'd14: r = 31'h0000FFFF;
			5'd15: r = 31'h00007FFF;
			5'd16: r = 31'h00003FFF;
			5'd17: r = 31'h00001FFF;
			5'd18: r = 31'h00000FFF;
			5'd19: r = 31'h000007FF;
			5'd20: r = 31'h000003FF;
			5'd21: r = 31'h000001FF;
			5'd22: r = 31'h000000FF;
			5'd23: r = 31'h0000007F;
			default: r = 31'h0;
		endcase
		return r;
	endfunction
endpackage

// ----- rtl/wcsf_mul.sv -----
// Shift-add unsigned multiplier, one multiplier bit per cycle, MSB first.
// Depends on wcsf_pkg.
module wcsf_mul import wcsf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic               done,
	output logic [MUL_P_W-1:0] p
);
	localparam int CNT_W = $clog2(MUL_B_W + 1);
	logic [MUL_A_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [MUL_P_W-1:0] p_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MUL_B_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= (p_q << 1) + (b_q[MUL_B_W-1] ? MUL_P_W'(a_q) : '0);
			b_q <= b_q << 1;
		end
	end

	assign done = done_q;
	assign p    = p_q;
endmodule

// ----- rtl/wcsf_sqrt.sv -----
// Digit-by-digit floor square root, two radicand bits per cycle.
// Depends on wcsf_pkg.
module wcsf_sqrt import wcsf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SQ_IN_W-1:0]  v,
	output logic                done,
	output logic [SQ_OUT_W-1:0] r
);
	localparam int CNT_W = $clog2(SQ_OUT_W + 1);
	logic [SQ_IN_W-1:0] op_q, one_q;
	logic [SQ_IN_W:0]   res_q, trial;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q, done_q;

	assign trial = res_q + {1'b0, one_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(SQ_OUT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= v;
			res_q <= '0;
			one_q <= SQ_IN_W'(1) << (SQ_IN_W - 2);
		end else if (busy_q) begin
			if ({1'b0, op_q} >= trial) begin
				op_q  <= op_q - trial[SQ_IN_W-1:0];
				res_q <= (res_q >> 1) + {1'b0, one_q};
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end

	assign done = done_q;
	assign r    = res_q[SQ_OUT_W-1:0];
endmodule

// ----- rtl/wcsf_cordic.sv -----
// Vectoring CORDIC: normalizes both operands one bit per cycle, then
// runs one rotation per cycle. Depends on wcsf_pkg.
module wcsf_cordic import wcsf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_P_W-1:0] num,
	input  logic [MUL_P_W-1:0] den,
	output logic               done,
	output logic [ANG_W-1:0]   angle
);
	logic [MUL_P_W-1:0]       xw_q, yw_q, orv;
	logic signed [CORD_W-1:0] x_q, y_q, z_q, xs, ys, zr;
	logic [STEP_W-1:0]        i_q;
	logic                     busy_q, norm_q, done_q, norm_hi, norm_lo;

	assign orv     = xw_q | yw_q;
	assign norm_hi = |orv[MUL_P_W-1:30];
	assign norm_lo = !orv[29];
	assign xs      = x_q >>> i_q;
	assign ys      = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			norm_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			norm_q <= 1'b1;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (busy_q) begin
			if (norm_q) begin
				if (!norm_hi && !norm_lo)
					norm_q <= 1'b0;
			end else begin
				i_q <= i_q + 1'b1;
				if (i_q == STEP_W'(ATAN_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xw_q <= den;
			yw_q <= num;
			z_q  <= '0;
		end else if (busy_q) begin
			if (norm_q) begin
				if (norm_hi) begin
					xw_q <= xw_q >> 1;
					yw_q <= yw_q >> 1;
				end else if (norm_lo) begin
					xw_q <= xw_q << 1;
					yw_q <= yw_q << 1;
				end else begin
					x_q <= CORD_W'(xw_q[29:0]);
					y_q <= CORD_W'(yw_q[29:0]);
				end
			end else if (!y_q[CORD_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + CORD_W'(atan_q30(5'(i_q)));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - CORD_W'(atan_q30(5'(i_q)));
			end
		end
	end

	// Q2.30 to Q2.13, round half up, clamp to the valid range
	assign zr = (z_q + CORD_W'(65536)) >>> 17;
	always_comb begin
		if (zr[CORD_W-1])
			angle = '0;
		else if (zr > CORD_W'(ANGLE_MAX))
			angle = ANG_W'(ANGLE_MAX);
		else
			angle = zr[ANG_W-1:0];
	end
	assign done = done_q;
endmodule

// ----- rtl/waypoint_curvature_steer_feedforward.sv -----
// Waypoint steering feedforward: takes one waypoint request per accepted item and
// emits at most one steering result per run.
// When a three-point window is evaluated, the sign test takes two multiplies
// and, if the window is chosen, the fit adds eleven more multiplies (only two
// when the window is straight), three square roots and a CORDIC pass of
// normalize steps plus 16 rotations.
// All of it runs through one shift-add multiplier, one root unit and one CORDIC
// unit under the sequencer below; the input is not ready meanwhile.
// Depends on wcsf_pkg, wcsf_mul, wcsf_sqrt, wcsf_cordic and the defines header.
`include "waypoint_curvature_steer_feedforward_defines.svh"
module waypoint_curvature_steer_feedforward import wcsf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // point_x, point_y, vehicle_x, vehicle_y
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,  // steer_angle[14:0], is_straight, turn_left, zero pad
	output logic [1:0]   m_tuser,  // status
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	state_t state_q, state_d;

	logic [19:0]            wb_q;
	logic signed [31:0]     wx_q [3];
	logic signed [31:0]     wy_q [3];
	logic signed [31:0]     cx_q, cy_q;
	logic [1:0]             pts_q;
	logic                   answer_q, last_q, left_q, launched_q;
	logic signed [ACC_W-1:0] acc_q, acc_nxt, sp;
	logic [SQ_IN_W-1:0]     sq_q;
	logic [SQ_OUT_W-1:0]    la_q, lb_q, lc_q;
	logic [MUL_P_W-1:0]     den_q, num_q;
	logic [14:0]            res_ang_q, out_ang_q;
	logic                   res_str_q, res_left_q, out_str_q, out_left_q, m_tvalid_q;
	status_t                res_st_q, out_st_q;

	logic                   in_acc, eval_new, out_free;
	logic [MUL_A_W-1:0]     mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic                   mul_neg, mul_start, sq_start, cor_start, unit_done;
	logic                   is_mul, is_sq;
	logic                   mul_done, sq_done, cor_done;
	logic [MUL_P_W-1:0]     mul_p;
	logic [SQ_OUT_W-1:0]    sq_r;
	logic [ANG_W-1:0]       cor_ang;
	logic signed [32:0]     dx10, dy10, dx21, dy21, dx20, dy20, dcx, dcy;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {12'd0, wb_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wb_q <= 20'd163840;
		else if (psel && penable && pwrite && !paddr[2])
			wb_q <= pwdata[19:0];
	end

	// ---------------- window differences ----------------
	assign dx10 = sdiff(wx_q[1], wx_q[0]);
	assign dy10 = sdiff(wy_q[1], wy_q[0]);
	assign dx21 = sdiff(wx_q[2], wx_q[1]);
	assign dy21 = sdiff(wy_q[2], wy_q[1]);
	assign dx20 = sdiff(wx_q[2], wx_q[0]);
	assign dy20 = sdiff(wy_q[2], wy_q[0]);
	assign dcx  = sdiff(cx_q, wx_q[1]);
	assign dcy  = sdiff(cy_q, wy_q[1]);

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign eval_new = !answer_q && (pts_q == 2'd2 || pts_q == 2'd3);
	assign out_free = !m_tvalid_q || m_tready;

	// ---------------- shared units ----------------
	wcsf_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .p(mul_p)
	);
	wcsf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .v(sq_q),
		.done(sq_done), .r(sq_r)
	);
	wcsf_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .num(num_q), .den(den_q),
		.done(cor_done), .angle(cor_ang)
	);

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (eval_new)
						state_d = S_DET0;
					else if (s_tlast && !answer_q)
						state_d = S_EMIT;
				end
			end
			S_DET0: if (unit_done) state_d = S_DET1;
			S_DET1: begin
				if (unit_done) begin
					if (acc_nxt[ACC_W-1])
						state_d = S_CRS0;
					else if (last_q)
						state_d = S_EMIT;
					else
						state_d = S_IDLE;
				end
			end
			S_CRS0: if (unit_done) state_d = S_CRS1;
			S_CRS1: if (unit_done) state_d = (acc_nxt == '0) ? S_EMIT : S_LA0;
			S_LA0:  if (unit_done) state_d = S_LA1;
			S_LA1:  if (unit_done) state_d = S_LA2;
			S_LA2:  if (unit_done) state_d = S_LB0;
			S_LB0:  if (unit_done) state_d = S_LB1;
			S_LB1:  if (unit_done) state_d = S_LB2;
			S_LB2:  if (unit_done) state_d = S_LC0;
			S_LC0:  if (unit_done) state_d = S_LC1;
			S_LC1:  if (unit_done) state_d = S_LC2;
			S_LC2:  if (unit_done) state_d = S_PAB;
			S_PAB:  if (unit_done) state_d = S_PABC;
			S_PABC: if (unit_done) state_d = S_NUM;
			S_NUM:  if (unit_done) state_d = S_ANG;
			S_ANG:  if (unit_done) state_d = S_EMIT;
			S_EMIT: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- sequencer: unit control ----------------
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		is_mul  = 1'b1;
		is_sq   = 1'b0;
		unique case (state_q)
			S_DET0: begin
				mul_a = MUL_A_W'(mag33(dy20));
				mul_b = MUL_B_W'(mag33(dcy));
				mul_neg = dy20[32] ^ dcy[32];
			end
			S_DET1: begin
				mul_a = MUL_A_W'(mag33(dx20));
				mul_b = MUL_B_W'(mag33(dcx));
				mul_neg = dx20[32] ^ dcx[32];
			end
			S_CRS0: begin
				mul_a = MUL_A_W'(mag33(dx10));
				mul_b = MUL_B_W'(mag33(dy21));
				mul_neg = dx10[32] ^ dy21[32];
			end
			S_CRS1: begin
				mul_a = MUL_A_W'(mag33(dy10));
				mul_b = MUL_B_W'(mag33(dx21));
				mul_neg = dy10[32] ^ dx21[32];
			end
			S_LA0: begin
				mul_a = MUL_A_W'(mag33(dx10));
				mul_b = MUL_B_W'(mag33(dx10));
			end
			S_LA1: begin
				mul_a = MUL_A_W'(mag33(dy10));
				mul_b = MUL_B_W'(mag33(dy10));
			end
			S_LB0: begin
				mul_a = MUL_A_W'(mag33(dx21));
				mul_b = MUL_B_W'(mag33(dx21));
			end
			S_LB1: begin
				mul_a = MUL_A_W'(mag33(dy21));
				mul_b = MUL_B_W'(mag33(dy21));
			end
			S_LC0: begin
				mul_a = MUL_A_W'(mag33(dx20));
				mul_b = MUL_B_W'(mag33(dx20));
			end
			S_LC1: begin
				mul_a = MUL_A_W'(mag33(dy20));
				mul_b = MUL_B_W'(mag33(dy20));
			end
			S_PAB: begin
				mul_a = MUL_A_W'(la_q);
				mul_b = MUL_B_W'(lb_q);
			end
			S_PABC: begin
				mul_a = den_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(lc_q);
			end
			S_NUM: begin
				mul_a = MUL_A_W'(acc_q);
				mul_b = MUL_B_W'({wb_q, 1'b0});
			end
			S_LA2, S_LB2, S_LC2: begin
				is_mul = 1'b0;
				is_sq  = 1'b1;
			end
			default: is_mul = 1'b0;
		endcase
	end

	assign mul_start = is_mul && !launched_q;
	assign sq_start  = is_sq && !launched_q;
	assign cor_start = (state_q == S_ANG) && !launched_q;
	assign unit_done = is_mul ? mul_done : (is_sq ? sq_done : cor_done);

	assign sp = mul_neg ? -ACC_W'(mul_p[SQ_IN_W-1:0]) : ACC_W'(mul_p[SQ_IN_W-1:0]);
	always_comb begin
		case (state_q)
			S_DET1:  acc_nxt = acc_q + sp;
			S_CRS1:  acc_nxt = acc_q - sp;
			default: acc_nxt = sp;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			launched_q <= 1'b0;
			pts_q      <= '0;
			answer_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			cx_q       <= '0;
			cy_q       <= '0;
		end else begin
			state_q <= state_d;
			if (mul_start || sq_start || cor_start)
				launched_q <= 1'b1;
			else if (unit_done)
				launched_q <= 1'b0;

			if (in_acc) begin
				if (pts_q == 2'd0) begin
					cx_q <= s_tdata[95:64];
					cy_q <= s_tdata[127:96];
				end
				if (!eval_new && s_tlast && answer_q) begin
					pts_q    <= '0;
					answer_q <= 1'b0;
				end else if (pts_q != 2'd3) begin
					pts_q <= pts_q + 1'b1;
				end
			end

			if ((state_q == S_CRS1 && unit_done && acc_nxt == '0) ||
			    (state_q == S_ANG && unit_done))
				answer_q <= 1'b1;

			if (state_q == S_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
				if (last_q) begin
					pts_q    <= '0;
					answer_q <= 1'b0;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			wx_q[0] <= wx_q[1];
			wx_q[1] <= wx_q[2];
			wx_q[2] <= s_tdata[31:0];
			wy_q[0] <= wy_q[1];
			wy_q[1] <= wy_q[2];
			wy_q[2] <= s_tdata[63:32];
			last_q  <= s_tlast;
			res_ang_q  <= '0;
			res_str_q  <= 1'b0;
			res_left_q <= 1'b0;
			res_st_q   <= (pts_q == 2'd0 || pts_q == 2'd1) ? ST_SHORT : ST_PAST;
		end
		if (unit_done) begin
			case (state_q)
				S_DET0, S_DET1, S_CRS0: acc_q <= acc_nxt;
				S_CRS1: begin
					acc_q  <= acc_nxt[ACC_W-1] ? -acc_nxt : acc_nxt;
					left_q <= !acc_nxt[ACC_W-1];
					if (acc_nxt == '0) begin
						res_ang_q  <= '0;
						res_str_q  <= 1'b1;
						res_left_q <= 1'b1;
						res_st_q   <= ST_OK;
					end
				end
				S_LA0, S_LB0, S_LC0: sq_q <= mul_p[SQ_IN_W-1:0];
				S_LA1, S_LB1, S_LC1: sq_q <= sq_q + mul_p[SQ_IN_W-1:0];
				S_LA2: la_q <= sq_r;
				S_LB2: lb_q <= sq_r;
				S_LC2: lc_q <= sq_r;
				S_PAB, S_PABC: den_q <= mul_p;
				S_NUM: num_q <= mul_p;
				S_ANG: begin
					res_ang_q  <= left_q ? 15'(cor_ang) : -15'(cor_ang);
					res_str_q  <= 1'b0;
					res_left_q <= left_q;
					res_st_q   <= ST_OK;
				end
				default: ;
			endcase
		end
		if (state_q == S_EMIT && out_free) begin
			out_ang_q  <= res_ang_q;
			out_str_q  <= res_str_q;
			out_left_q <= res_left_q;
			out_st_q   <= res_st_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_left_q, out_str_q, out_ang_q};
	assign m_tuser  = out_st_q;

	// ---------------- checks ----------------
	`WCSF_ASSERT_IMP(a_answer_full, answer_q, pts_q == 2'd3)
	`WCSF_ASSERT_IMP(a_launch_busy, launched_q, state_q != S_IDLE && state_q != S_EMIT)
	`WCSF_ASSERT_NXT(a_emit_hold, state_q == S_EMIT && m_tvalid_q && !m_tready, state_q == S_EMIT)
	`WCSF_ASSERT_IMP(a_straight_zero, m_tvalid_q && out_str_q, out_ang_q == 15'd0)
endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for waypoint_curvature_steer_feedforward: streams waypoint runs,
// predicts each run's steering result and scores the output stream against it.
// Depends on wcsf_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;
	import wcsf_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE = 900;
	localparam int ITEMS = 1750;
	localparam logic [2:0] REG_WHEELBASE = 3'd0;
	localparam longint ATAN_TBL [0:23] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	typedef struct {
		logic signed [31:0] px, py, vx, vy;
		logic last;
	} waypoint_t;

	typedef struct {
		logic [14:0] steer;
		logic straight;
		logic left;
		logic [1:0] status;
	} steer_t;

	class steer_scoreboard;
		steer_t pending[$];
		int errors;
		int checked;
		logic [19:0] wheelbase;
		logic signed [31:0] win_x[3], win_y[3];
		logic signed [31:0] car_x, car_y;
		int seen;
		bit answered;

		function new();
			errors = 0;
			checked = 0;
			wheelbase = 20'd163840;
			car_x = 0;
			car_y = 0;
			seen = 0;
			answered = 0;
		endfunction

		function logic [127:0] isqrt(logic [127:0] v);
			logic [127:0] r, cand;
			r = 0;
			for (int b = 34; b >= 0; b--) begin
				cand = r | (128'd1 << b);
				if (cand * cand <= v)
					r = cand;
			end
			return r;
		endfunction

		function logic [127:0] len_sq(logic signed [127:0] dx, logic signed [127:0] dy);
			return dx * dx + dy * dy;
		endfunction

		// CORDIC vectoring: atan2(num, den) in Q2.13, clamped
		function longint cordic_angle(logic [127:0] num, logic [127:0] den);
			logic [127:0] big;
			int m;
			longint x, y, z, xs, ys;
			big = (num <= den) ? den : num;
			m = -1;
			z = 0;
			for (int i = 127; i >= 0; i--)
				if (big[i] && m < 0)
					m = i;
			if (m > 29) begin
				num = num >> (m - 29);
				den = den >> (m - 29);
			end
			x = longint'(den[63:0]);
			y = longint'(num[63:0]);
			if (m >= 0 && m < 29) begin
				x = x <<< (29 - m);
				y = y <<< (29 - m);
			end
			for (int i = 0; i < ATAN_STEPS && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + ATAN_TBL[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - ATAN_TBL[i];
				end
			end
			z = (z + (64'sd1 <<< 16)) >>> 17;
			if (z < 0)
				z = 0;
			if (z > ANGLE_MAX)
				z = ANGLE_MAX;
			return z;
		endfunction

		function steer_t fit_window();
			logic signed [127:0] ax, ay, bx, by, crs;
			logic [127:0] acr, la, lb, lc;
			longint ang;
			steer_t r;
			ax = 128'(win_x[1]) - 128'(win_x[0]);
			ay = 128'(win_y[1]) - 128'(win_y[0]);
			bx = 128'(win_x[2]) - 128'(win_x[1]);
			by = 128'(win_y[2]) - 128'(win_y[1]);
			crs = ax * by - ay * bx;
			r.left = (crs >= 0);
			r.status = ST_OK;
			acr = r.left ? crs : -crs;
			if (acr == 0) begin
				r.steer = 0;
				r.straight = 1;
				return r;
			end
			la = isqrt(len_sq(ax, ay));
			lb = isqrt(len_sq(bx, by));
			lc = isqrt(len_sq(ax + bx, ay + by));
			ang = cordic_angle(acr * 2 * 128'(wheelbase), la * lb * lc);
			if (!r.left)
				ang = -ang;
			r.steer = ang[14:0];
			r.straight = 0;
			return r;
		endfunction

		function void note_request(waypoint_t w);
			logic signed [127:0] p, q;
			steer_t r;
			if (seen == 0) begin
				car_x = w.vx;
				car_y = w.vy;
			end
			win_x[0] = win_x[1];
			win_x[1] = win_x[2];
			win_x[2] = w.px;
			win_y[0] = win_y[1];
			win_y[1] = win_y[2];
			win_y[2] = w.py;
			if (seen < 3)
				seen++;
			if (!answered && seen == 3) begin
				p = (128'(win_y[2]) - 128'(win_y[0])) * (128'(car_y) - 128'(win_y[1]));
				q = (128'(win_x[2]) - 128'(win_x[0])) * (128'(car_x) - 128'(win_x[1]));
				if (p + q < 0) begin
					pending.push_back(fit_window());
					answered = 1;
				end
			end
			if (w.last) begin
				if (!answered) begin
					r.steer = 0;
					r.straight = 0;
					r.left = 0;
					r.status = (seen == 3) ? ST_PAST : ST_SHORT;
					pending.push_back(r);
				end
				seen = 0;
				answered = 0;
			end
		endfunction

		function void check_result(steer_t act);
			steer_t exp_r;
			bit bad;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result steer=%0d straight=%0b left=%0b status=%0d",
					$time, $signed(act.steer), act.straight, act.left, act.status);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			checked++;
			bad = 0;
			if (act.steer !== exp_r.steer) begin
				$display("%0t: steer_angle expected %0d actual %0d", $time,
					$signed(exp_r.steer), $signed(act.steer));
				bad = 1;
			end
			if (act.straight !== exp_r.straight) begin
				$display("%0t: is_straight expected %0b actual %0b", $time,
					exp_r.straight, act.straight);
				bad = 1;
			end
			if (act.left !== exp_r.left) begin
				$display("%0t: turn_left expected %0b actual %0b", $time, exp_r.left, act.left);
				bad = 1;
			end
			if (act.status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_r.status, act.status);
				bad = 1;
			end
			if (bad)
				errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [127:0] s_tdata = '0;  // point_x, point_y, vehicle_x, vehicle_y
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [23:0] m_tdata;  // steer_angle[14:0], is_straight, turn_left, zero pad
	logic [1:0] m_tuser;  // status
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	steer_scoreboard sb = new();
	bit quiet = 0;
	int sent = 0;
	int runs = 0;
	int cycles = 0;
	int stall_left = 0;

	waypoint_curvature_steer_feedforward u_top (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result('{m_tdata[14:0], m_tdata[15], m_tdata[16], m_tuser});

	// result-side backpressure in short bursts
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			m_tready = arst_n;
			stall_left = 0;
		end else if (stall_left > 0) begin
			m_tready = 0;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready = 0;
			stall_left = $urandom_range(0, 2);
		end else begin
			m_tready = 1;
		end
	end

	task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
			logic [31:0] vy, logic last);
		waypoint_t w;
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			s_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		w = '{px, py, vx, vy, last};
		s_tdata = {vy, vx, py, px};
		s_tlast = last;
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(w);
		sent++;
		if (last)
			runs++;
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		sb.wheelbase = data[19:0];
	endtask

	// drain results, then let a silent evaluation finish
	task automatic wait_idle();
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Mostly well-formed: points march ahead of the vehicle with some bend.
	task automatic send_path(int npts, bit wide_span, bit forward);
		longint bx, by, dx, dy, cx, cy, vx, vy, px, py;
		int span;
		span = wide_span ? 30 : 20;
		bx = longint'($signed($urandom())) >>> (wide_span ? 1 : 10);
		by = longint'($signed($urandom())) >>> (wide_span ? 1 : 10);
		dx = longint'($urandom_range(0, 2 << span)) - (longint'(1) << span);
		dy = longint'($urandom_range(0, 2 << span)) - (longint'(1) << span);
		cx = longint'($urandom_range(0, 2 << (span - 3))) - (longint'(1) << (span - 3));
		cy = longint'($urandom_range(0, 2 << (span - 3))) - (longint'(1) << (span - 3));
		if ($urandom_range(0, 7) == 0) begin
			cx = 0;
			cy = 0;
		end
		if (forward) begin
			vx = bx - dx * $urandom_range(1, 4);
			vy = by - dy * $urandom_range(1, 4);
		end else begin
			vx = bx + dx * $urandom_range(8, 20);
			vy = by + dy * $urandom_range(8, 20);
		end
		for (int i = 0; i < npts; i++) begin
			px = bx + dx * i + cx * i * i;
			py = by + dy * i + cy * i * i;
			send_point(px[31:0], py[31:0], vx[31:0], vy[31:0], i == npts - 1);
		end
	endtask

	task automatic directed_items();
		// too few points
		send_point(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1);
		send_point(0, 0, 0, 0, 0);
		send_point(65536, 0, 0, 0, 1);
		// collinear
		send_point(0, 0, -65536, 0, 0);
		send_point(65536, 0, 0, 0, 0);
		send_point(131072, 0, 0, 0, 1);
		// left, with extra points after the answer
		send_point(0, 0, -65536, 0, 0);
		send_point(65536, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		send_point(131072, 65536, 0, 0, 0);
		send_point(32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0);
		send_point(196608, 196608, 0, 0, 1);
		// right
		send_point(0, 0, -65536, 0, 0);
		send_point(65536, 0, 0, 0, 0);
		send_point(131072, -65536, 0, 0, 1);
		// vehicle ahead of every window
		send_point(0, 0, 655360, 0, 0);
		send_point(65536, 0, 0, 0, 0);
		send_point(131072, 0, 0, 0, 0);
		send_point(196608, 0, 0, 0, 1);
		// coordinate extremes
		send_point(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 0);
		send_point(32'h80000000, 32'h7FFFFFFF, 0, 0, 0);
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1);
		send_point(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
		send_point(32'h80000000, 32'h7FFFFFFF, 0, 0, 0);
		send_point(32'h7FFFFFFF, 32'h80000000, 0, 0, 1);
	endtask

	task automatic random_items(int target);
		int kind, n;
		while (sent < target) begin
			if (sent > ITEMS - 150)
				quiet = 1;
			kind = $urandom_range(0, 9);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
			if (kind < 6)
				send_path(n, 0, 1);
			else if (kind == 6)
				send_path(n, 1, 1);
			else if (kind == 7)
				send_path(n, $urandom_range(0, 1), 0);
			else
				for (int i = 0; i < n; i++)
					send_point($urandom(), $urandom(), $urandom(), $urandom(), i == n - 1);
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		directed_items();
		wait_idle();
		apb_write(REG_WHEELBASE, 32'd0);
		random_items(250);
		wait_idle();
		apb_write(REG_WHEELBASE, 32'd655360);
		random_items(650);
		wait_idle();
		apb_write(REG_WHEELBASE, 32'hFFFFF);
		random_items(900);
		wait_idle();
		apb_write(REG_WHEELBASE, $urandom_range(1, 655360));
		random_items(1300);
		wait_idle();
		apb_write(REG_WHEELBASE, 32'd163840);
		random_items(ITEMS);
		wait_idle();
		$display("Sent %0d waypoints in %0d runs over five wheelbase settings;", sent, runs);
		$display("checked %0d steering results, %0d mismatched.", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/wcsf_pkg.sv
rtl/wcsf_mul.sv
rtl/wcsf_sqrt.sv
rtl/wcsf_cordic.sv
rtl/waypoint_curvature_steer_feedforward.sv
tb/testbench.sv
